// File: rtl/piclc_pkg.sv
// ----------------------------------------------------------------------------
// piclc_pkg
// Shared types and constants of the PI current-limit controller: register
// indexes, reset values, divider and scaling sizes, state encoding and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package piclc_pkg;

    // scaling of both gains
    localparam int unsigned SCALE_DIV = 100;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN  = 2'd1;
    localparam logic [1:0] REG_PWM_LIMIT   = 2'd2;
    localparam logic [1:0] REG_DRIVE_CLAMP = 2'd3;

    // reset values
    localparam logic [15:0] RST_PROP_GAIN   = 16'd100;
    localparam logic [15:0] RST_INTEG_GAIN  = 16'd10;
    localparam logic [15:0] RST_PWM_LIMIT   = 16'd1000;
    localparam logic [14:0] RST_DRIVE_CLAMP = 15'd1000;

    // bound divider: dividend wide enough for pwm_limit * 100
    localparam int unsigned DIV_W = 23;
    localparam int unsigned CNT_W = $clog2(DIV_W);

    // largest drive magnitude worth scaling: anything above gives a
    // quotient past the widest possible drive clamp
    localparam int unsigned DRV_MAG_W = 22;
    localparam logic [DRV_MAG_W-1:0] DRIVE_MAG_SAT = DRV_MAG_W'(SCALE_DIV * 32768 - 1);

    // magnitude / 100 as (m * ceil(2^29 / 100)) >> 29, exact for m < 2^22
    localparam int unsigned DRV_SHIFT = 29;
    localparam logic [22:0] DRV_RECIP = 23'd5368710;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_INTEG,
        S_MULT,
        S_ACC,
        S_LOAD,
        S_DRIVE,
        S_OUT
    } t_state;

    // configuration register set
    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] pwm_limit;
        logic [14:0] drive_clamp;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic start;        // capture error, start integral bound division
        logic update_integ; // add error, clamp integral
        logic mult;         // form both gain products
        logic acc;          // sum the products
        logic load_drv;     // capture drive sign and saturated magnitude
        logic scale;        // reciprocal multiply for magnitude / 100
        logic write_out;    // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/piclc_cfg_regs.sv
// ----------------------------------------------------------------------------
// piclc_cfg_regs
// Configuration register file: plain indexed write, no read-back.
// ----------------------------------------------------------------------------
module piclc_cfg_regs import piclc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= RST_PROP_GAIN;
            r_cfg.integ_gain  <= RST_INTEG_GAIN;
            r_cfg.pwm_limit   <= RST_PWM_LIMIT;
            r_cfg.drive_clamp <= RST_DRIVE_CLAMP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_wdata;
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_wdata;
                REG_PWM_LIMIT:   r_cfg.pwm_limit   <= i_cfg_wdata;
                REG_DRIVE_CLAMP: r_cfg.drive_clamp <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/piclc_div.sv
// ----------------------------------------------------------------------------
// piclc_div
// Restoring unsigned divider, one quotient bit per cycle. Forms the integral
// bound pwm_limit * 100 / integ_gain.
// ----------------------------------------------------------------------------
module piclc_div import piclc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [15:0]      i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_done
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [15:0]      r_dvs;

    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_ge;

    // one trial subtraction
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[15:0] : w_trial[15:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: rtl/piclc_ctrl.sv
// ----------------------------------------------------------------------------
// piclc_ctrl
// Sequencer for one sample: bound division, integral update, products,
// sum, drive scaling, output write.
// ----------------------------------------------------------------------------
module piclc_ctrl import piclc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_BOUND;
            S_BOUND: if (i_sts.div_done) n_state = S_INTEG;
            S_INTEG: n_state = S_MULT;
            S_MULT:  n_state = S_ACC;
            S_ACC:   n_state = S_LOAD;
            S_LOAD:  n_state = S_DRIVE;
            S_DRIVE: n_state = S_OUT;
            S_OUT:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start = i_in_valid;
            end
            S_INTEG: o_cmd.update_integ = 1'b1;
            S_MULT:  o_cmd.mult = 1'b1;
            S_ACC:   o_cmd.acc = 1'b1;
            S_LOAD:  o_cmd.load_drv = 1'b1;
            S_DRIVE: o_cmd.scale = 1'b1;
            S_OUT:   o_cmd.write_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/piclc_datapath.sv
// ----------------------------------------------------------------------------
// piclc_datapath
// Error, clamped integral, gain products, signed scaling by 100 and the
// output register.
// ----------------------------------------------------------------------------
module piclc_datapath import piclc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic signed [15:0] i_measured_current,
    input  logic signed [15:0] i_target_current,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive_value
);

    logic signed [16:0]   r_err;
    logic signed [23:0]   r_integ;
    logic signed [33:0]   r_p1;
    logic signed [40:0]   r_p2;
    logic signed [41:0]   r_acc;
    logic                 r_neg;
    logic [DRV_MAG_W-1:0] r_mag;
    logic [14:0]          r_dquo;
    logic                 r_out_valid;
    logic signed [15:0]   r_out_data;

    logic [DIV_W-1:0]     w_quotient;
    logic                 w_div_done;
    logic [DIV_W-1:0]     w_dividend;
    logic [15:0]          w_divisor;

    logic signed [24:0]   w_sum;
    logic signed [24:0]   w_bound;
    logic signed [24:0]   w_bound_n;
    logic signed [23:0]   w_integ_clamped;
    logic [41:0]          w_mag;
    logic [DRV_MAG_W-1:0] w_mag_sat;
    logic [43:0]          w_scaled;
    logic [14:0]          w_lim;
    logic signed [15:0]   w_drive;

    // bound division operands; zero gain bounds as if it were one
    assign w_dividend = DIV_W'(i_cfg.pwm_limit * SCALE_DIV);
    assign w_divisor  = (i_cfg.integ_gain == 16'd0) ? 16'd1 : i_cfg.integ_gain;

    piclc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quotient),
        .o_done     (w_div_done)
    );

    // integral plus error, clamped to the bound
    assign w_sum     = 25'(r_integ) + 25'(r_err);
    assign w_bound   = $signed({2'b00, w_quotient});
    assign w_bound_n = -w_bound;

    always_comb begin
        if (w_sum > w_bound) begin
            w_integ_clamped = w_bound[23:0];
        end else if (w_sum < w_bound_n) begin
            w_integ_clamped = w_bound_n[23:0];
        end else begin
            w_integ_clamped = w_sum[23:0];
        end
    end

    // drive magnitude, saturated to what the clamp can ever pass
    assign w_mag     = r_acc[41] ? 42'(-r_acc) : 42'(r_acc);
    assign w_mag_sat = (w_mag > 42'(DRIVE_MAG_SAT)) ? DRIVE_MAG_SAT
                                                    : w_mag[DRV_MAG_W-1:0];

    // magnitude / 100 by reciprocal multiply, truncating
    assign w_scaled = {22'd0, r_mag} * {21'd0, DRV_RECIP};

    // drive: clamp magnitude, restore sign
    assign w_lim   = (r_dquo > i_cfg.drive_clamp) ? i_cfg.drive_clamp : r_dquo;
    assign w_drive = r_neg ? -$signed({1'b0, w_lim}) : $signed({1'b0, w_lim});

    // integral state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.update_integ) begin
            r_integ <= w_integ_clamped;
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_err <= 17'(i_target_current) - 17'(i_measured_current);
        end
        if (i_cmd.mult) begin
            r_p1 <= $signed({1'b0, i_cfg.prop_gain}) * r_err;
            r_p2 <= $signed({1'b0, i_cfg.integ_gain}) * r_integ;
        end
        if (i_cmd.acc) begin
            r_acc <= 42'(r_p1) + 42'(r_p2);
        end
        if (i_cmd.load_drv) begin
            r_neg <= r_acc[41];
            r_mag <= w_mag_sat;
        end
        if (i_cmd.scale) begin
            r_dquo <= w_scaled[DRV_SHIFT +: 15];
        end
        if (i_cmd.write_out) begin
            r_out_data <= w_drive;
        end
    end

    // output word holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_drive_value  = r_out_data;

endmodule

// File: rtl/pi_current_limit_controller_unit.sv
// ----------------------------------------------------------------------------
// pi_current_limit_controller_unit
// PI current controller with integral anti-windup clamp.
//
// Input stream: one word per sample, measured current in tdata[15:0] and
// target current in tdata[31:16], both two's complement. Output stream: one
// drive word per sample, tdata[15:0], clamped to +/- the drive clamp.
// Gains and limits are set on the write port (index 0 prop_gain,
// 1 integ_gain, 2 pwm_limit, 3 drive clamp) while the block is idle.
//
// Each sample runs through the integral bound division, in which the
// one-bit-per-cycle divider runs 23 steps, then the integral, product, sum,
// magnitude, scaling and output steps; no new sample is accepted until the
// sequencer returns to idle after the output step.
// The output register decouples the sides: a new sample is taken while the
// last drive word still waits. If the receiver stalls, the next result waits
// in the sequencer until the output register frees, and no further sample is
// accepted meanwhile.
// Reset (synchronous, active low) clears the integral, loads the register
// reset values and empties the output; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pi_current_limit_controller_unit import piclc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] measured_current, [31:16] target_current
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] drive_value
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg               w_cfg;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic signed [15:0] w_drive;

    piclc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    piclc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    piclc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_measured_current (i_s_axis_tdata[15:0]),
        .i_target_current   (i_s_axis_tdata[31:16]),
        .o_out_valid        (o_m_axis_tvalid),
        .i_out_ready        (i_m_axis_tready),
        .o_drive_value      (w_drive)
    );

    assign o_m_axis_tdata = w_drive;

    // a taken sample keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still open after accepting a sample");

    // a delivered drive word lies within the output clamp
    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata) <= $signed({1'b0, w_cfg.drive_clamp})
                          && $signed(o_m_axis_tdata) >= -$signed({1'b0, w_cfg.drive_clamp})))
        else $error("drive word outside the drive clamp");

    // the output register is only loaded when empty or while its word is taken
    a_write_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.write_out && o_m_axis_tvalid) |-> i_m_axis_tready)
        else $error("output word overwritten before it was taken");

endmodule
